// ----- src/point_in_polygon_crossing_unit_assert.svh -----
// Assertion macros shared by the point-in-polygon crossing unit files.
`ifndef POINT_IN_POLYGON_CROSSING_UNIT_ASSERT_SVH
`define POINT_IN_POLYGON_CROSSING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PIPC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pipc assertion failed");
`define PIPC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pipc assertion failed");
`else
`define PIPC_ASSERT_IMP(label, ante, cons)
`define PIPC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- src/pipc_pkg.sv -----
// Shared types and constants of the point-in-polygon crossing unit.
package pipc_pkg;

    localparam int EPS_BITS     = 23;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUNDARY_MODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OVERLAP_RESULT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOUNDARY_EPS   = 2'd2;

    typedef struct packed {
        logic                mode;
        logic [EPS_BITS-1:0] eps;
    } t_edge_cfg;

    typedef struct packed {
        logic boundary;
        logic toggle;
    } t_edge_res;

endpackage

// ----- src/pipc_vtx_if.sv -----
// Vertex input channel: valid/ready handshake with one polygon vertex and query point.
interface pipc_vtx_if #(
    parameter int COORD_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_of_path;
    logic                         last_of_set;

    modport source (
        output valid, vertex_x, vertex_y, point_x, point_y, last_of_path, last_of_set,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, point_x, point_y, last_of_path, last_of_set,
        output ready
    );
endinterface

// ----- src/pipc_res_if.sv -----
// Result output channel: valid/ready handshake with the inside and boundary flags.
interface pipc_res_if ();
    logic valid;
    logic ready;
    logic is_inside;
    logic on_boundary;

    modport source (
        output valid, is_inside, on_boundary,
        input  ready
    );
    modport sink (
        input  valid, is_inside, on_boundary,
        output ready
    );
endinterface

// ----- src/pipc_edge_eval.sv -----
// Edge evaluator: boundary and crossing test of one edge on a shared multiplier.
`include "point_in_polygon_crossing_unit_assert.svh"
module pipc_edge_eval #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  pipc_pkg::t_edge_cfg          i_cfg,
    input  logic signed [COORD_BITS-1:0] i_x0,
    input  logic signed [COORD_BITS-1:0] i_y0,
    input  logic signed [COORD_BITS-1:0] i_x1,
    input  logic signed [COORD_BITS-1:0] i_y1,
    input  logic signed [COORD_BITS-1:0] i_qx,
    input  logic signed [COORD_BITS-1:0] i_qy,
    output logic                         o_done,
    output pipc_pkg::t_edge_res          o_res
);

    localparam int DW = COORD_BITS + 1;
    localparam int CW = (DW > pipc_pkg::EPS_BITS) ? DW : pipc_pkg::EPS_BITS;
    localparam int MW = (DW > pipc_pkg::EPS_BITS + 1) ? DW : pipc_pkg::EPS_BITS + 1;
    localparam int PW = 2 * MW;
    localparam int NW = PW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MA   = 3'd2;
    localparam logic [2:0] ST_MB   = 3'd3;
    localparam logic [2:0] ST_MC   = 3'd4;
    localparam logic [2:0] ST_SUM  = 3'd5;
    localparam logic [2:0] ST_CMP  = 3'd6;

    function automatic logic f_near(
        input logic signed [COORD_BITS-1:0]   a,
        input logic signed [COORD_BITS-1:0]   b,
        input logic [pipc_pkg::EPS_BITS-1:0]  e
    );
        logic signed [DW-1:0] d;
        logic        [DW-1:0] m;
        d = DW'(a) - DW'(b);
        m = d[DW-1] ? -d : d;
        return CW'(m) < CW'(e);
    endfunction

    logic [2:0]           r_state, n_state;
    logic signed [DW-1:0] r_ax, r_by, r_dx, r_dy;
    logic        [DW-1:0] r_ady;
    logic signed [PW-1:0] r_prod, r_acc;
    logic signed [NW-1:0] r_num;
    logic        [NW-1:0] r_mag;
    logic                 r_flip;
    logic                 r_done;
    pipc_pkg::t_edge_res  r_res;

    logic signed [MW-1:0] w_opa, w_opb;
    logic signed [PW-1:0] w_prod;
    logic                 w_hit, w_hline, w_sa, w_sb, w_straddle, w_bnd;
    logic                 w_nx0, w_nx1;

    assign w_nx0   = f_near(i_qx, i_x0, i_cfg.eps);
    assign w_nx1   = f_near(i_qx, i_x1, i_cfg.eps);
    assign w_hline = f_near(i_y0, i_y1, i_cfg.eps) && f_near(i_y1, i_qy, i_cfg.eps);
    assign w_sa    = (i_qx > i_x1 || w_nx1) && (i_qx < i_x0 || w_nx0);
    assign w_sb    = (i_qx > i_x0 || w_nx0) && (i_qx < i_x1 || w_nx1);
    assign w_hit   = (w_nx1 && f_near(i_qy, i_y1, i_cfg.eps)) || (w_hline && (w_sa || w_sb));
    assign w_straddle = (i_y0 <= i_qy && i_qy < i_y1) || (i_y1 <= i_qy && i_qy < i_y0);

    always_comb begin
        case (r_state)
            ST_MA: begin
                w_opa = MW'(r_ax);
                w_opb = MW'(r_dy);
            end
            ST_MB: begin
                w_opa = MW'(r_by);
                w_opb = MW'(r_dx);
            end
            ST_MC: begin
                w_opa = MW'({1'b0, i_cfg.eps});
                w_opb = MW'({1'b0, r_ady});
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_prod = w_opa * w_opb;
    assign w_bnd  = i_cfg.mode && (r_mag < {1'b0, r_prod});

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_start) n_state = ST_PREP;
            ST_PREP: begin
                if ((i_cfg.mode && w_hit) || !w_straddle) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_MA;
                end
            end
            ST_MA:   n_state = ST_MB;
            ST_MB:   n_state = ST_MC;
            ST_MC:   n_state = ST_SUM;
            ST_SUM:  n_state = ST_CMP;
            ST_CMP:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_PREP && n_state == ST_IDLE) || (r_state == ST_CMP);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_PREP: begin
                r_ax  <= DW'(i_x0) - DW'(i_qx);
                r_by  <= DW'(i_qy) - DW'(i_y0);
                r_dx  <= DW'(i_x1) - DW'(i_x0);
                r_dy  <= DW'(i_y1) - DW'(i_y0);
                r_res <= '{boundary: i_cfg.mode && w_hit, toggle: 1'b0};
            end
            ST_MA: begin
                r_prod <= w_prod;
                r_ady  <= r_dy[DW-1] ? -r_dy : r_dy;
            end
            ST_MB: begin
                r_acc  <= r_prod;
                r_prod <= w_prod;
            end
            ST_MC: begin
                r_num  <= NW'(r_acc) + NW'(r_prod);
                r_prod <= w_prod;
            end
            ST_SUM: begin
                r_mag  <= r_num[NW-1] ? -r_num : r_num;
                r_flip <= r_dy[DW-1] ? (!r_num[NW-1] && r_num != '0) : r_num[NW-1];
            end
            ST_CMP: begin
                r_res <= '{boundary: w_bnd, toggle: !w_bnd && r_flip};
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `PIPC_ASSERT_NXT(a_done_pulse, o_done, !o_done)
    `PIPC_ASSERT_IMP(a_res_excl, o_done, !(o_res.boundary && o_res.toggle))
    `PIPC_ASSERT_IMP(a_mb_after_ma, r_state == ST_MB, $past(r_state) == ST_MA)
    `PIPC_ASSERT_IMP(a_done_idle, o_done, r_state == ST_IDLE)

endmodule

// ----- src/point_in_polygon_crossing_unit.sv -----
// Top level of the streamed even-odd point-in-polygon crossing unit.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  i_vtx    | in  | valid/ready        | vertex_x/y, point_x/y, last_of_path/set
//  o_res    | out | valid/ready        | is_inside, on_boundary
//  i_cfg_*  | in  | write enable only  | i_cfg_idx, i_cfg_data
//
//  A vertex that opens a path without closing it runs no edge.
//  Any other vertex runs its edges in turn, on the shared multiplier unless the
//  compares alone settle an edge; a vertex that closes a path also runs its closing edge.
//  After its edges, a set's last vertex moves its result into the output register,
//  and stalls there only while the previous result still waits for its transfer.
//  Synchronous active-low reset; no clearing pass.
`include "point_in_polygon_crossing_unit_assert.svh"
module point_in_polygon_crossing_unit #(
    parameter int COORD_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    pipc_vtx_if.sink                               i_vtx,
    pipc_res_if.source                             o_res,
    input  logic                                   i_cfg_we,
    input  logic [pipc_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [pipc_pkg::EPS_BITS-1:0]          i_cfg_data
);

    localparam logic [1:0] T_IDLE   = 2'd0;
    localparam logic [1:0] T_LAUNCH = 2'd1;
    localparam logic [1:0] T_WAIT   = 2'd2;
    localparam logic [1:0] T_OUT    = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic                         r_mode, r_ovl;
    logic [pipc_pkg::EPS_BITS-1:0] r_eps;
    logic signed [COORD_BITS-1:0] r_qx, r_qy, r_sx, r_sy, r_px, r_py;
    logic signed [COORD_BITS-1:0] r_ex0, r_ey0, r_ex1, r_ey1;
    logic                         r_await_first, r_await_set;
    logic                         r_parity, r_seen;
    logic                         r_close_pend, r_end_set;
    logic                         r_out_vld, r_out_inside, r_out_bnd;

    logic                         w_accept, w_first, w_close, w_done, w_out_free;
    logic signed [COORD_BITS-1:0] w_vx, w_vy;
    pipc_pkg::t_edge_cfg          w_cfg;
    pipc_pkg::t_edge_res          w_res;

    assign w_vx       = i_vtx.vertex_x;
    assign w_vy       = i_vtx.vertex_y;
    assign w_accept   = i_vtx.valid && (r_state == T_IDLE);
    assign w_first    = r_await_set || r_await_first;
    assign w_close    = i_vtx.last_of_path || i_vtx.last_of_set;
    assign w_cfg      = '{mode: r_mode, eps: r_eps};
    assign w_out_free = !r_out_vld || o_res.ready;

    pipc_edge_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_LAUNCH),
        .i_cfg   (w_cfg),
        .i_x0    (r_ex0),
        .i_y0    (r_ey0),
        .i_x1    (r_ex1),
        .i_y1    (r_ey1),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE:   if (w_accept && (!w_first || w_close)) n_state = T_LAUNCH;
            T_LAUNCH: n_state = T_WAIT;
            T_WAIT: begin
                if (w_done) begin
                    if (r_close_pend) begin
                        n_state = T_LAUNCH;
                    end else if (r_end_set) begin
                        n_state = T_OUT;
                    end else begin
                        n_state = T_IDLE;
                    end
                end
            end
            T_OUT:    if (w_out_free) n_state = T_IDLE;
            default:  n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= T_IDLE;
            r_mode        <= 1'b0;
            r_ovl         <= 1'b0;
            r_eps         <= pipc_pkg::EPS_BITS'(1);
            r_await_first <= 1'b1;
            r_await_set   <= 1'b1;
            r_parity      <= 1'b0;
            r_seen        <= 1'b0;
            r_close_pend  <= 1'b0;
            r_end_set     <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pipc_pkg::CFG_BOUNDARY_MODE:  r_mode <= i_cfg_data[0];
                    pipc_pkg::CFG_OVERLAP_RESULT: r_ovl  <= i_cfg_data[0];
                    pipc_pkg::CFG_BOUNDARY_EPS:   r_eps  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_await_first <= w_close;
                r_await_set   <= i_vtx.last_of_set;
                r_end_set     <= i_vtx.last_of_set;
                r_close_pend  <= !w_first && w_close;
                if (r_await_set) begin
                    r_parity <= 1'b0;
                    r_seen   <= 1'b0;
                end
            end else if (r_state == T_WAIT && w_done) begin
                r_parity     <= r_parity ^ w_res.toggle;
                r_seen       <= r_seen | w_res.boundary;
                r_close_pend <= 1'b0;
            end
            if (r_state == T_OUT && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (r_await_set) begin
                r_qx <= i_vtx.point_x;
                r_qy <= i_vtx.point_y;
            end
            if (w_first) begin
                r_sx <= w_vx;
                r_sy <= w_vy;
            end
            r_px <= w_vx;
            r_py <= w_vy;
            if (!w_first) begin
                r_ex0 <= r_px;
                r_ey0 <= r_py;
            end else begin
                r_ex0 <= w_vx;
                r_ey0 <= w_vy;
            end
            r_ex1 <= w_vx;
            r_ey1 <= w_vy;
        end else if (r_state == T_WAIT && w_done && r_close_pend) begin
            r_ex0 <= r_px;
            r_ey0 <= r_py;
            r_ex1 <= r_sx;
            r_ey1 <= r_sy;
        end
        if (r_state == T_OUT && w_out_free) begin
            r_out_inside <= r_seen ? r_ovl : r_parity;
            r_out_bnd    <= r_seen;
        end
    end

    assign i_vtx.ready       = (r_state == T_IDLE);
    assign o_res.valid       = r_out_vld;
    assign o_res.is_inside   = r_out_inside;
    assign o_res.on_boundary = r_out_bnd;

    `PIPC_ASSERT_IMP(a_done_in_wait, w_done, r_state == T_WAIT)
    `PIPC_ASSERT_IMP(a_load_no_pend, r_state == T_OUT, !r_close_pend && r_end_set)
    `PIPC_ASSERT_IMP(a_load_set_closed, r_state == T_OUT, r_await_set && r_await_first)
    `PIPC_ASSERT_NXT(a_out_hold, o_res.valid && !o_res.ready, o_res.valid)
    `PIPC_ASSERT_NXT(a_out_stable_in, o_res.valid && !o_res.ready, $stable(o_res.is_inside))
    `PIPC_ASSERT_NXT(a_out_stable_bnd, o_res.valid && !o_res.ready, $stable(o_res.on_boundary))

endmodule

// ----- tb/pipc_crossing_checker.sv -----
`timescale 1ns / 100ps
// Crossing-parity checker: watches the vertex, configuration and result channels, predicts and compares.
module pipc_crossing_checker #(
    parameter int COORD_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pipc_vtx_if                               i_vtx,
    pipc_res_if                               i_res,
    input  logic                              i_cfg_we,
    input  logic [pipc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [pipc_pkg::EPS_BITS-1:0]     i_cfg_data,
    output int                                o_pending,
    output int                                o_fail_count
);

    typedef struct packed {
        logic in_shape;
        logic boundary;
    } t_set_flags;

    t_set_flags set_flags_q[$];

    longint start_x, start_y, prev_x, prev_y, query_x, query_y;
    bit     awaiting_first     = 1'b1;
    bit     awaiting_set_start = 1'b1;
    bit     parity;
    bit     boundary_seen;
    bit     cfg_mode;
    bit     cfg_overlap;
    logic [pipc_pkg::EPS_BITS-1:0] cfg_eps = 1;
    int     fails = 0;

    function automatic longint mag(input longint a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic bit close_to(input longint a, input longint b);
        return mag(a - b) < longint'(cfg_eps);
    endfunction

    function automatic void cross_edge(input longint x0, y0, x1, y1);
        longint dy;
        longint num;
        bit     hit;
        hit = 1'b0;
        if (cfg_mode) begin
            hit = close_to(query_x, x1) && close_to(query_y, y1);
            if (!hit && close_to(y0, y1) && close_to(y1, query_y)) begin
                hit = ((query_x > x1 || close_to(query_x, x1)) &&
                       (query_x < x0 || close_to(query_x, x0))) ||
                      ((query_x > x0 || close_to(query_x, x0)) &&
                       (query_x < x1 || close_to(query_x, x1)));
            end
        end
        if (hit) begin
            boundary_seen = 1'b1;
            return;
        end
        if ((y0 <= query_y && query_y < y1) || (y1 <= query_y && query_y < y0)) begin
            dy  = y1 - y0;
            num = (x0 - query_x) * dy + (query_y - y0) * (x1 - x0);
            if (dy < 0) begin
                num = -num;
            end
            if (cfg_mode && mag(num) < longint'(cfg_eps) * mag(dy)) begin
                boundary_seen = 1'b1;
            end else if (num < 0) begin
                parity = !parity;
            end
        end
    endfunction

    function automatic void take_vertex(input longint vx, vy, px, py,
                                        input bit end_path, end_set);
        t_set_flags flags;
        if (awaiting_set_start) begin
            query_x            = px;
            query_y            = py;
            parity             = 1'b0;
            boundary_seen      = 1'b0;
            awaiting_set_start = 1'b0;
            awaiting_first     = 1'b1;
        end
        if (awaiting_first) begin
            start_x        = vx;
            start_y        = vy;
            awaiting_first = 1'b0;
        end else begin
            cross_edge(prev_x, prev_y, vx, vy);
        end
        prev_x = vx;
        prev_y = vy;
        if (end_path || end_set) begin
            cross_edge(vx, vy, start_x, start_y);
            awaiting_first = 1'b1;
        end
        if (end_set) begin
            flags.in_shape     = boundary_seen ? cfg_overlap : parity;
            flags.boundary     = boundary_seen;
            set_flags_q        = {set_flags_q, flags};
            awaiting_set_start = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_set_flags want;
        if (!i_rst_n) begin
            start_x            = 0;
            start_y            = 0;
            prev_x             = 0;
            prev_y             = 0;
            query_x            = 0;
            query_y            = 0;
            awaiting_first     = 1'b1;
            awaiting_set_start = 1'b1;
            parity             = 1'b0;
            boundary_seen      = 1'b0;
            cfg_mode           = 1'b0;
            cfg_overlap        = 1'b0;
            cfg_eps            = 1;
            set_flags_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (set_flags_q.size() == 0) begin
                    $error("result transfer with no set outstanding: %s %0b, %s %0b",
                           "is_inside", i_res.is_inside, "on_boundary", i_res.on_boundary);
                    fails++;
                end else begin
                    want = set_flags_q.pop_front();
                    if (i_res.is_inside !== want.in_shape) begin
                        $error("is_inside mismatch: expected %0b, actual %0b",
                               want.in_shape, i_res.is_inside);
                        fails++;
                    end
                    if (i_res.on_boundary !== want.boundary) begin
                        $error("on_boundary mismatch: expected %0b, actual %0b",
                               want.boundary, i_res.on_boundary);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pipc_pkg::CFG_BOUNDARY_MODE:  cfg_mode    = i_cfg_data[0];
                    pipc_pkg::CFG_OVERLAP_RESULT: cfg_overlap = i_cfg_data[0];
                    pipc_pkg::CFG_BOUNDARY_EPS:   cfg_eps     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_vtx.valid && i_vtx.ready) begin
                take_vertex(i_vtx.vertex_x, i_vtx.vertex_y, i_vtx.point_x, i_vtx.point_y,
                            i_vtx.last_of_path, i_vtx.last_of_set);
            end
        end
        o_pending    <= set_flags_q.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/tb_point_in_polygon_crossing_unit.sv -----
`timescale 1ns / 100ps
// Testbench top: drives vertex sets and configuration into the crossing unit, gives the verdict.
module tb_point_in_polygon_crossing_unit;

    localparam int COORD_BITS      = 24;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 600;
    localparam int RANDOM_VERTICES = 2000;
    localparam int PHASES          = 10;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [pipc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [pipc_pkg::EPS_BITS-1:0]     i_cfg_data;
    int                                pending;
    int                                fail_count;
    int                                vertex_count = 0;
    bit                                quiet;
    bit                                hold_req;

    pipc_vtx_if #(.COORD_BITS(COORD_BITS)) vtx_bus ();
    pipc_res_if                            res_bus ();

    point_in_polygon_crossing_unit #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vtx      (vtx_bus),
        .o_res      (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    pipc_crossing_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vtx        (vtx_bus),
        .i_res        (res_bus),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_coord near_coord(input t_coord c, input int spread);
        if (spread == 0) begin
            return t_coord'($urandom);
        end
        if ($urandom_range(0, 7) == 0) begin
            return c;
        end
        return t_coord'(int'(c) + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic send_vertex(input t_coord vx, vy, px, py, input bit end_path, end_set);
        while (!quiet && $urandom_range(0, 99) < 25) begin
            vtx_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        vtx_bus.valid        <= 1'b1;
        vtx_bus.vertex_x     <= vx;
        vtx_bus.vertex_y     <= vy;
        vtx_bus.point_x      <= px;
        vtx_bus.point_y      <= py;
        vtx_bus.last_of_path <= end_path;
        vtx_bus.last_of_set  <= end_set;
        @(posedge i_clk);
        while (!vtx_bus.ready) begin
            @(posedge i_clk);
        end
        vertex_count++;
    endtask

    task automatic write_config(input bit mode, input bit overlap,
                                input logic [pipc_pkg::EPS_BITS-1:0] eps);
        logic [pipc_pkg::EPS_BITS-1:0] filler;
        filler     = pipc_pkg::EPS_BITS'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pipc_pkg::CFG_BOUNDARY_MODE;
        i_cfg_data <= {filler[pipc_pkg::EPS_BITS-1:1], mode};
        @(posedge i_clk);
        i_cfg_idx  <= pipc_pkg::CFG_OVERLAP_RESULT;
        i_cfg_data <= {filler[pipc_pkg::EPS_BITS-2:0], overlap};
        @(posedge i_clk);
        i_cfg_idx  <= pipc_pkg::CFG_BOUNDARY_EPS;
        i_cfg_data <= eps;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic settle();
        vtx_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : receiver
        bit held;
        held = 1'b0;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                res_bus.ready <= quiet || ($urandom_range(0, 99) >= 25);
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_coord                        px, py;
        int                            spread, paths, corners, budget, target;
        bit                            end_path, end_set, mode, overlap;
        logic [pipc_pkg::EPS_BITS-1:0] eps;

        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= pipc_pkg::CFG_BOUNDARY_MODE;
        i_cfg_data           <= '0;
        vtx_bus.valid        <= 1'b0;
        vtx_bus.vertex_x     <= '0;
        vtx_bus.vertex_y     <= '0;
        vtx_bus.point_x      <= '0;
        vtx_bus.point_y      <= '0;
        vtx_bus.last_of_path <= 1'b0;
        vtx_bus.last_of_set  <= 1'b0;
        quiet                <= 1'b0;
        hold_req             <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain parity: set end closes the open path, full-scale square, hole plus lone vertex
        write_config(1'b0, 1'b0, 1);
        send_vertex(-10, -10, 1, 1, 1'b0, 1'b0);
        send_vertex(10, -10, t_coord'($urandom), t_coord'($urandom), 1'b0, 1'b0);
        send_vertex(0, 10, t_coord'($urandom), t_coord'($urandom), 1'b0, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, 0, 0, 1'b0, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
        send_vertex(-20, -20, 0, 0, 1'b0, 1'b0);
        send_vertex(20, -20, 3, 3, 1'b0, 1'b0);
        send_vertex(20, 20, 3, 3, 1'b0, 1'b0);
        send_vertex(-20, 20, 3, 3, 1'b1, 1'b0);
        send_vertex(5, 5, 3, 3, 1'b1, 1'b0);
        send_vertex(-5, -5, 3, 3, 1'b0, 1'b0);
        send_vertex(5, -5, 3, 3, 1'b0, 1'b0);
        send_vertex(0, 5, 3, 3, 1'b1, 1'b1);

        // boundary: point on a vertex and a horizontal edge, then near a crossing
        settle();
        write_config(1'b1, 1'b1, 2);
        send_vertex(0, 0, 0, 0, 1'b0, 1'b0);
        send_vertex(10, 0, 7, 7, 1'b0, 1'b0);
        send_vertex(0, 10, 7, 7, 1'b1, 1'b1);
        send_vertex(0, 0, 5, 4, 1'b0, 1'b0);
        send_vertex(10, 10, 0, 0, 1'b0, 1'b0);
        send_vertex(0, 10, 0, 0, 1'b1, 1'b1);

        // zero tolerance never flags a boundary
        settle();
        write_config(1'b1, 1'b0, 0);
        send_vertex(0, 0, 0, 0, 1'b0, 1'b0);
        send_vertex(10, 0, 1, 1, 1'b0, 1'b0);
        send_vertex(0, 10, 1, 1, 1'b1, 1'b1);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            mode    = ($urandom_range(0, 3) != 0);
            overlap = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       eps = 1;
                1:       eps = pipc_pkg::EPS_BITS'($urandom_range(0, 4));
                2:       eps = pipc_pkg::EPS_BITS'($urandom_range(0, 64));
                default: eps = pipc_pkg::EPS_BITS'($urandom);
            endcase
            if (phase == 0) begin
                mode = 1'b1;
                eps  = '1;
            end else if (phase == 1) begin
                mode = 1'b1;
                eps  = '0;
            end
            write_config(mode, overlap, eps);
            quiet <= (phase == 2);
            if (phase == 3) begin
                hold_req <= 1'b1;
            end
            target = vertex_count + RANDOM_VERTICES / PHASES;
            while (vertex_count < target) begin
                case ($urandom_range(0, 3))
                    0:       spread = 2;
                    1:       spread = 24;
                    2:       spread = 3000;
                    default: spread = 0;
                endcase
                px = t_coord'($urandom);
                py = t_coord'($urandom);
                if ($urandom_range(0, 7) == 0) begin
                    px = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                    py = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                end
                if ($urandom_range(0, 9) == 0) begin
                    // noise: flags at random until the set ends, at the latest on its twelfth vertex
                    budget = 0;
                    do begin
                        budget++;
                        end_path = ($urandom_range(0, 3) == 0);
                        end_set  = ($urandom_range(0, 5) == 0) || budget == 12;
                        send_vertex(near_coord(px, spread), near_coord(py, spread),
                                    budget == 1 ? px : t_coord'($urandom),
                                    budget == 1 ? py : t_coord'($urandom), end_path, end_set);
                    end while (!end_set);
                end else begin
                    paths = $urandom_range(1, 3);
                    for (int p = 0; p < paths; p++) begin
                        corners = $urandom_range(1, 6);
                        for (int k = 0; k < corners; k++) begin
                            end_set  = (p == paths - 1) && (k == corners - 1);
                            end_path = (k == corners - 1) && (!end_set || $urandom_range(0, 1));
                            send_vertex(near_coord(px, spread), near_coord(py, spread),
                                        (p == 0 && k == 0) ? px : t_coord'($urandom),
                                        (p == 0 && k == 0) ? py : t_coord'($urandom),
                                        end_path, end_set);
                        end
                    end
                end
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
